// ----- hdl/spa_pkg.sv -----
// Shared types, constants and rounding helpers for the sine unit.
// No dependencies; every other file of the block imports this package.
package spa_pkg;

  localparam int IF_BITS = 30;
  localparam int QUO_W   = 32;
  localparam int COEF_W  = 28;

  localparam longint ONE_L = 64'sd1 <<< IF_BITS;

  localparam logic [32:0] TWO_PI_Q    = 33'd6746518852;
  localparam logic [31:0] PI_Q        = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q   = 31'd1686629713;
  localparam logic [29:0] SIXTH_PI_Q  = 30'd562209904;
  localparam logic [30:0] SMALL_Q     = 31'd10;
  localparam logic [31:0] ONE_Q       = 32'd1073741824;
  localparam logic [31:0] THIRD_RECIP = 32'hAAAAAAAB;

  // Pade coefficients, normalized by the common constant term, rounded to nearest
  localparam longint COEF_NORM = 64'sd5324;
  localparam longint NUM_D2 = 64'sd39 * COEF_NORM;
  localparam longint NUM_D4 = 64'sd1430 * COEF_NORM;
  localparam longint NUM_D6 = 64'sd2162169 * COEF_NORM;
  localparam longint DEN_D2 = 64'sd13 * COEF_NORM;
  localparam longint DEN_D4 = 64'sd66 * COEF_NORM;
  localparam longint DEN_D6 = 64'sd308880 * COEF_NORM;

  localparam longint NUM_C2_L = (64'sd29593 * ONE_L + NUM_D2 / 2) / NUM_D2;
  localparam longint NUM_C4_L = (64'sd34911 * ONE_L + NUM_D4 / 2) / NUM_D4;
  localparam longint NUM_C6_L = (64'sd479249 * ONE_L + NUM_D6 / 2) / NUM_D6;
  localparam longint DEN_C2_L = (64'sd1671 * ONE_L + DEN_D2 / 2) / DEN_D2;
  localparam longint DEN_C4_L = (64'sd97 * ONE_L + DEN_D4 / 2) / DEN_D4;
  localparam longint DEN_C6_L = (64'sd2623 * ONE_L + DEN_D6 / 2) / DEN_D6;

  localparam logic [COEF_W-1:0] NUM_C2 = NUM_C2_L[COEF_W-1:0];
  localparam logic [COEF_W-1:0] NUM_C4 = NUM_C4_L[COEF_W-1:0];
  localparam logic [COEF_W-1:0] NUM_C6 = NUM_C6_L[COEF_W-1:0];
  localparam logic [COEF_W-1:0] DEN_C2 = DEN_C2_L[COEF_W-1:0];
  localparam logic [COEF_W-1:0] DEN_C4 = DEN_C4_L[COEF_W-1:0];
  localparam logic [COEF_W-1:0] DEN_C6 = DEN_C6_L[COEF_W-1:0];

  typedef struct packed {
    logic               tiny;
    logic               triple;
    logic signed [31:0] x;
    logic signed [30:0] u;
  } spa_side_t;

  // round a nonnegative Q.60 product back to Q.30, half up
  function automatic logic [31:0] rnd_u(input logic [63:0] p);
    logic [63:0] t;
    t = (p + (64'd1 << (IF_BITS - 1))) >> IF_BITS;
    return t[31:0];
  endfunction

  // round a signed Q.60 product back to Q.30, half toward plus infinity
  function automatic logic signed [31:0] rnd_s(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (64'sd1 <<< (IF_BITS - 1))) >>> IF_BITS;
    return t[31:0];
  endfunction

endpackage

// ----- hdl/spa_reduce.sv -----
// Angle front end: format conversion, modulo 2pi, fold, divide by three.
// Depends on spa_pkg.
module spa_reduce #(
  parameter int ANGLE_FRAC_BITS = 27
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] angle,
  output logic               vld_o,
  output spa_pkg::spa_side_t side_o
);
  import spa_pkg::*;

  localparam int XW    = (ANGLE_FRAC_BITS <= IF_BITS) ? 62 - ANGLE_FRAC_BITS
                                                      : 63 - ANGLE_FRAC_BITS;
  localparam int NSTEP = (XW > 34) ? XW - 33 : 1;
  localparam int MW    = (XW > 34) ? XW : 34;

  localparam logic signed [33:0] PI_S   = $signed({2'b00, PI_Q});
  localparam logic signed [33:0] TWO_S  = $signed({1'b0, TWO_PI_Q});
  localparam logic signed [33:0] HALF_S = $signed({3'b000, HALF_PI_Q});

  logic signed [XW-1:0] x_conv;
  logic [XW-1:0]        mag_x;

  generate
    if (ANGLE_FRAC_BITS <= IF_BITS) begin : g_up
      assign x_conv = XW'(angle) <<< (IF_BITS - ANGLE_FRAC_BITS);
    end else begin : g_dn
      localparam int SH = ANGLE_FRAC_BITS - IF_BITS;
      logic signed [32:0] a_rnd;
      assign a_rnd  = 33'(angle) + (33'sd1 <<< (SH - 1));
      assign x_conv = XW'(a_rnd >>> SH);
    end
  endgenerate

  assign mag_x = x_conv[XW-1] ? $unsigned(-x_conv) : $unsigned(x_conv);

  logic          vld_r [0:NSTEP];
  logic          neg_r [0:NSTEP];
  logic [MW-1:0] mag_r [0:NSTEP];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    neg_r[0] <= x_conv[XW-1];
    mag_r[0] <= MW'(mag_x);
  end

  // one conditional subtract of a power-of-two multiple of 2pi per stage
  generate
    for (genvar j = 0; j < NSTEP; j++) begin : g_mod
      localparam logic [MW-1:0] SUB = MW'(TWO_PI_Q) << (NSTEP - 1 - j);
      logic [MW-1:0] step_nxt;
      assign step_nxt = (mag_r[j] >= SUB) ? mag_r[j] - SUB : mag_r[j];
      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[j+1] <= 1'b0;
        else        vld_r[j+1] <= vld_r[j];
      end
      always_ff @(posedge clk) begin
        neg_r[j+1] <= neg_r[j];
        mag_r[j+1] <= step_nxt;
      end
    end
  endgenerate

  // wrap into (-pi, pi]
  logic signed [33:0] rm_s, wrap_nxt, wrap_r;
  logic               wrap_vld_r;
  assign rm_s = $signed({1'b0, mag_r[NSTEP][32:0]});

  always_comb begin
    if (!neg_r[NSTEP]) begin
      wrap_nxt = (rm_s > PI_S) ? rm_s - TWO_S : rm_s;
    end else if (rm_s == 34'sd0) begin
      wrap_nxt = 34'sd0;
    end else if (TWO_S - rm_s > PI_S) begin
      wrap_nxt = -rm_s;
    end else begin
      wrap_nxt = TWO_S - rm_s;
    end
  end

  // fold into [-pi/2, pi/2]
  logic signed [33:0] fold_w;
  logic signed [31:0] fold_r;
  logic               fold_vld_r;
  always_comb begin
    if (wrap_r > HALF_S)       fold_w = PI_S - wrap_r;
    else if (wrap_r < -HALF_S) fold_w = -PI_S - wrap_r;
    else                       fold_w = wrap_r;
  end

  // magnitude, path flags and the multiply by the reciprocal of three
  logic [30:0] m_abs;
  logic [31:0] m_inc;
  logic [63:0] prod_nxt, prod_r;
  logic        tiny_r, triple_r, mul_vld_r;
  logic signed [31:0] xm_r;
  assign m_abs    = fold_r[31] ? 31'(-fold_r) : 31'(fold_r);
  assign m_inc    = 32'(m_abs) + 32'd1;
  assign prod_nxt = m_inc * THIRD_RECIP;

  logic signed [30:0] t_s, u_nxt;
  assign t_s   = $signed(prod_r[63:33]);
  assign u_nxt = !triple_r ? $signed(xm_r[30:0]) : (xm_r[31] ? -t_s : t_s);

  spa_side_t side_r;
  logic      side_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_vld_r <= 1'b0;
      fold_vld_r <= 1'b0;
      mul_vld_r  <= 1'b0;
      side_vld_r <= 1'b0;
    end else begin
      wrap_vld_r <= vld_r[NSTEP];
      fold_vld_r <= wrap_vld_r;
      mul_vld_r  <= fold_vld_r;
      side_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    wrap_r        <= wrap_nxt;
    fold_r        <= fold_w[31:0];
    prod_r        <= prod_nxt;
    xm_r          <= fold_r;
    tiny_r        <= m_abs <= SMALL_Q;
    triple_r      <= m_abs >= 31'(SIXTH_PI_Q);
    side_r.tiny   <= tiny_r;
    side_r.triple <= triple_r;
    side_r.x      <= xm_r;
    side_r.u      <= u_nxt;
  end

  assign vld_o  = side_vld_r;
  assign side_o = side_r;

endmodule

// ----- hdl/spa_poly.sv -----
// Power chain and Pade numerator / denominator sums.
// Depends on spa_pkg.
module spa_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  spa_pkg::spa_side_t side_i,
  output logic               vld_o,
  output spa_pkg::spa_side_t side_o,
  output logic [31:0]        num_o,
  output logic [31:0]        den_o
);
  import spa_pkg::*;

  localparam int NST = 5;

  logic      vld_r  [0:NST-1];
  spa_side_t side_r [0:NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_i;
    for (int i = 1; i < NST; i++) side_r[i] <= side_r[i-1];
  end

  logic [29:0] umag;
  assign umag = side_i.u[30] ? 30'(-side_i.u) : 30'(side_i.u);

  logic [31:0] s1_u2_r;
  logic [31:0] s2_u2_r, s2_u4_r, s2_n2_r, s2_d2_r;
  logic [31:0] s3_u6_r, s3_n2_r, s3_d2_r, s3_n4_r, s3_d4_r;
  logic [31:0] s4_n2_r, s4_d2_r, s4_n4_r, s4_d4_r, s4_n6_r, s4_d6_r;
  logic [31:0] num_r, den_r;

  logic signed [33:0] num_sum;
  logic [31:0]        den_sum;
  assign num_sum = 34'(ONE_Q) + 34'(s4_n4_r) - 34'(s4_n2_r) - 34'(s4_n6_r);
  assign den_sum = ONE_Q + s4_d2_r + s4_d4_r + s4_d6_r;

  always_ff @(posedge clk) begin
    s1_u2_r <= rnd_u(64'(umag) * 64'(umag));

    s2_u2_r <= s1_u2_r;
    s2_u4_r <= rnd_u(64'(s1_u2_r) * 64'(s1_u2_r));
    s2_n2_r <= rnd_u(64'(NUM_C2) * 64'(s1_u2_r));
    s2_d2_r <= rnd_u(64'(DEN_C2) * 64'(s1_u2_r));

    s3_u6_r <= rnd_u(64'(s2_u4_r) * 64'(s2_u2_r));
    s3_n4_r <= rnd_u(64'(NUM_C4) * 64'(s2_u4_r));
    s3_d4_r <= rnd_u(64'(DEN_C4) * 64'(s2_u4_r));
    s3_n2_r <= s2_n2_r;
    s3_d2_r <= s2_d2_r;

    s4_n6_r <= rnd_u(64'(NUM_C6) * 64'(s3_u6_r));
    s4_d6_r <= rnd_u(64'(DEN_C6) * 64'(s3_u6_r));
    s4_n2_r <= s3_n2_r;
    s4_d2_r <= s3_d2_r;
    s4_n4_r <= s3_n4_r;
    s4_d4_r <= s3_d4_r;

    // clamp a negative numerator to zero
    num_r <= num_sum[33] ? 32'd0 : num_sum[31:0];
    den_r <= den_sum;
  end

  assign vld_o  = vld_r[NST-1];
  assign side_o = side_r[NST-1];
  assign num_o  = num_r;
  assign den_o  = den_r;

  a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] |-> den_r >= ONE_Q)
    else $error("denominator below one");

endmodule

// ----- hdl/spa_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, rounded quotient.
// Depends on spa_pkg.
module spa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  spa_pkg::spa_side_t side_i,
  input  logic [31:0]        num_i,
  input  logic [31:0]        den_i,
  output logic               vld_o,
  output spa_pkg::spa_side_t side_o,
  output logic [31:0]        ratio_o
);
  import spa_pkg::*;

  logic [63:0] dvd;
  assign dvd = ({32'd0, num_i} << IF_BITS) + 64'(den_i >> 1);

  logic             vld_r  [0:QUO_W-1];
  logic [63:0]      rem_r  [0:QUO_W-1];
  logic [31:0]      den_r  [0:QUO_W-1];
  logic [QUO_W-1:0] quo_r  [0:QUO_W-1];
  spa_side_t        side_r [0:QUO_W-1];

  generate
    for (genvar j = 0; j < QUO_W; j++) begin : g_bit
      localparam int K = QUO_W - 1 - j;
      logic             vld_in;
      logic [63:0]      rem_in;
      logic [31:0]      den_in;
      logic [QUO_W-1:0] quo_in;
      spa_side_t        side_in;
      logic [63:0]      sub;
      logic             take;

      if (j == 0) begin : g_first
        assign vld_in  = vld_i;
        assign rem_in  = dvd;
        assign den_in  = den_i;
        assign quo_in  = '0;
        assign side_in = side_i;
      end else begin : g_next
        assign vld_in  = vld_r[j-1];
        assign rem_in  = rem_r[j-1];
        assign den_in  = den_r[j-1];
        assign quo_in  = quo_r[j-1];
        assign side_in = side_r[j-1];
      end

      assign sub  = 64'(den_in) << K;
      assign take = rem_in >= sub;

      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[j] <= 1'b0;
        else        vld_r[j] <= vld_in;
      end

      always_ff @(posedge clk) begin
        rem_r[j]     <= take ? rem_in - sub : rem_in;
        den_r[j]     <= den_in;
        quo_r[j]     <= quo_in | (QUO_W'(take) << K);
        side_r[j]    <= side_in;
      end
    end
  endgenerate

  assign vld_o   = vld_r[QUO_W-1];
  assign side_o  = side_r[QUO_W-1];
  assign ratio_o = quo_r[QUO_W-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QUO_W-1] |-> rem_r[QUO_W-1] < 64'(den_r[QUO_W-1]))
    else $error("quotient overflowed the divider width");

endmodule

// ----- hdl/spa_fin.sv -----
// Back end: scale by u, triple-angle step, path select, saturate, output format.
// Depends on spa_pkg.
module spa_fin #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  spa_pkg::spa_side_t side_i,
  input  logic [31:0]        ratio_i,
  output logic               out_valid,
  output logic signed [31:0] out_sine
);
  import spa_pkg::*;

  localparam int NST = 4;
  localparam logic signed [31:0] ONE_S   = $signed(ONE_Q);
  localparam logic signed [33:0] THREE_S = 34'sd3221225472;

  logic      vld_r  [0:NST-1];
  spa_side_t side_r [0:NST-1];
  logic      out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_i;
    for (int i = 1; i < NST; i++) side_r[i] <= side_r[i-1];
  end

  logic signed [31:0] s1_s_r, s2_s_r, s2_sq_r, s3_s_r, s4_s_r, s4_t_r;
  logic signed [33:0] s3_v_r;

  always_ff @(posedge clk) begin
    s1_s_r  <= rnd_s(64'($signed({1'b0, ratio_i})) * 64'(side_i.u));
    s2_s_r  <= s1_s_r;
    s2_sq_r <= rnd_s(64'(s1_s_r) * 64'(s1_s_r));
    s3_s_r  <= s2_s_r;
    s3_v_r  <= THREE_S - (34'(s2_sq_r) <<< 2);
    s4_s_r  <= s3_s_r;
    s4_t_r  <= rnd_s(64'(s3_s_r) * 64'(s3_v_r));
  end

  logic signed [31:0] sel, sat, conv;
  always_comb begin
    if (side_r[NST-1].tiny)        sel = side_r[NST-1].x;
    else if (side_r[NST-1].triple) sel = s4_t_r;
    else                           sel = s4_s_r;
    if (sel > ONE_S)       sat = ONE_S;
    else if (sel < -ONE_S) sat = -ONE_S;
    else                   sat = sel;
  end

  generate
    if (RESULT_FRAC_BITS >= IF_BITS) begin : g_up
      assign conv = sat <<< (RESULT_FRAC_BITS - IF_BITS);
    end else begin : g_dn
      localparam int SH = IF_BITS - RESULT_FRAC_BITS;
      assign conv = (sat + (32'sd1 <<< (SH - 1))) >>> SH;
    end
  endgenerate

  logic signed [31:0] sine_r;
  always_ff @(posedge clk) begin
    sine_r <= conv;
  end

  assign out_valid = out_vld_r;
  assign out_sine  = sine_r;

  a_path_excl: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] |-> !(side_r[NST-1].tiny && side_r[NST-1].triple))
    else $error("tiny-angle and triple-angle paths both selected");

endmodule

// ----- hdl/sine_pade_approximation.sv -----
// Top level of the fixed-point sine unit.
// Depends on spa_pkg, spa_reduce, spa_poly, spa_div and spa_fin.
//
// Sine of a signed fixed-point angle, fully pipelined: one angle may be
// transferred on every clock cycle (start high while busy is low) and each
// result appears exactly once, for one cycle, with out_valid high, in the
// order the angles came in. The receiver cannot stall the unit, so nothing
// backs up: busy is high only during reset and the cycle after it.
// The 32-stage divider (one quotient bit per stage) makes up most of the
// pipeline; the modulo-2pi reduction adds one stage per bit of possible
// turn count.
// Angle format: ANGLE_FRAC_BITS fraction bits. Result format:
// RESULT_FRAC_BITS fraction bits, saturated to plus or minus one, low 32
// bits delivered.
module sine_pade_approximation #(
  parameter int ANGLE_FRAC_BITS  = 27,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_sine
);
  import spa_pkg::*;

  // hold off transfers while reset is applied and in the cycle after it
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end
  assign busy = busy_r;

  logic in_xfer;
  assign in_xfer = start && !busy_r;

  // front end: convert, drop whole turns, fold, split off x/3
  logic      red_vld;
  spa_side_t red_side;
  spa_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_xfer),
    .angle  (in_angle),
    .vld_o  (red_vld),
    .side_o (red_side)
  );

  // powers of u and both Pade polynomials
  logic        poly_vld;
  spa_side_t   poly_side;
  logic [31:0] poly_num, poly_den;
  spa_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (red_vld),
    .side_i (red_side),
    .vld_o  (poly_vld),
    .side_o (poly_side),
    .num_o  (poly_num),
    .den_o  (poly_den)
  );

  // rounded quotient num / den
  logic        div_vld;
  spa_side_t   div_side;
  logic [31:0] div_ratio;
  spa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (poly_vld),
    .side_i  (poly_side),
    .num_i   (poly_num),
    .den_i   (poly_den),
    .vld_o   (div_vld),
    .side_o  (div_side),
    .ratio_o (div_ratio)
  );

  // advance through scaling, triple angle, saturation and output format
  spa_fin #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (div_vld),
    .side_i    (div_side),
    .ratio_i   (div_ratio),
    .out_valid (out_valid),
    .out_sine  (out_sine)
  );

  a_busy_only_in_reset: assert property (@(posedge clk)
    $past(rst_n) && rst_n |-> !busy)
    else $error("busy raised outside reset");

  a_no_xfer_in_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_no_early_result: assert property (@(posedge clk)
    busy |-> !out_valid)
    else $error("result strobe while busy");

endmodule
